/* sv/weighted_mean_3x3_filter_macros.svh */
// Assertion macros for the weighted mean filter RTL.
`ifndef WEIGHTED_MEAN_3X3_FILTER_MACROS_SVH
`define WEIGHTED_MEAN_3X3_FILTER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define WMF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a condition in one cycle forces another in the next cycle.
`define WMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/wmf_pkg.sv */
package wmf_pkg;

    // Fixed field widths
    localparam int PIXEL_BITS     = 8;
    localparam int OPCODE_BITS    = 1;
    localparam int WIDTH_CFG_BITS = 9;
    localparam int HEIGHT_BITS    = 13;
    localparam int ROW_BITS       = 12;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 1;

    // Frame geometry limits
    localparam int SIDE_MIN   = 3;
    localparam int HEIGHT_MAX = 4096;

    // Request opcodes
    localparam logic [OPCODE_BITS-1:0] OP_PIXEL = 1'b0;
    localparam logic [OPCODE_BITS-1:0] OP_DRAIN = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Window and arithmetic sizes
    localparam int WIN_COLS     = 3;
    localparam int CENTRE_SHIFT = 2;   // four extra copies of the centre
    localparam int SUM_BITS     = 11;  // one weighted column, at most 7 * 255
    localparam int TOTAL_BITS   = 12;  // whole window, at most 13 * 255
    localparam int RECIP_BITS   = 13;
    localparam int RECIP_SHIFT  = 15;
    localparam int QUOT_BITS    = RECIP_SHIFT + PIXEL_BITS;

    // Reciprocals scaled by 2^15; exact floor for sums up to 13 * 255
    localparam logic [RECIP_BITS-1:0] RECIP_CORNER = 13'd4096;  // 1/8
    localparam logic [RECIP_BITS-1:0] RECIP_EDGE   = 13'd3277;  // 1/10
    localparam logic [RECIP_BITS-1:0] RECIP_INNER  = 13'd2521;  // 1/13

    typedef enum logic [1:0] {
        DIV_CORNER = 2'd0,
        DIV_EDGE   = 2'd1,
        DIV_INNER  = 2'd2
    } t_div;

    // One window column: row above, centre row, row below
    typedef struct packed {
        logic [PIXEL_BITS-1:0] top;
        logic [PIXEL_BITS-1:0] mid;
        logic [PIXEL_BITS-1:0] bot;
    } t_column;

    // Control handed to each window cell
    typedef struct packed {
        logic shift;
        logic advance;
        logic row_top;
        logic row_bot;
        logic col_off;
        logic centre;
    } t_cell_ctl;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  last;
    } t_result;

    function automatic logic [RECIP_BITS-1:0] recip_of(input t_div code);
        logic [RECIP_BITS-1:0] m;
        unique case (code)
            DIV_CORNER: m = RECIP_CORNER;
            DIV_EDGE:   m = RECIP_EDGE;
            DIV_INNER:  m = RECIP_INNER;
            default:    m = RECIP_INNER;
        endcase
        return m;
    endfunction

endpackage

/* sv/wmf_linebuf.sv */
module wmf_linebuf #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]          i_wr_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]          i_rd_addr,
    input  logic [wmf_pkg::PIXEL_BITS-1:0]        i_pixel,
    output wmf_pkg::t_column                      o_col
);
    import wmf_pkg::*;

    // Two rows per column: older is two rows back, newer one row back
    typedef struct packed {
        logic [PIXEL_BITS-1:0] older;
        logic [PIXEL_BITS-1:0] newer;
    } t_pair;

    t_pair r_mem [MAX_WIDTH];
    t_pair r_rd;
    t_pair n_wr;

    // Push the new pixel in, age the one-row-back pixel
    always_comb begin
        n_wr.older = r_rd.newer;
        n_wr.newer = i_pixel;
    end

    // Write the current column, prefetch the next one
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= n_wr;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    // Entering window column
    always_comb begin
        o_col.top = r_rd.older;
        o_col.mid = r_rd.newer;
        o_col.bot = i_pixel;
    end

endmodule

/* sv/wmf_cell.sv */
module wmf_cell (
    input  logic                             i_clk,
    input  wmf_pkg::t_cell_ctl               i_ctl,
    input  wmf_pkg::t_column                 i_col,
    output wmf_pkg::t_column                 o_col,
    output logic [wmf_pkg::SUM_BITS-1:0]     o_sum
);
    import wmf_pkg::*;

    t_column               r_pix_col;
    logic [SUM_BITS-1:0]   r_sum;
    logic [SUM_BITS-1:0]   top_v;
    logic [SUM_BITS-1:0]   mid_v;
    logic [SUM_BITS-1:0]   bot_v;
    logic [SUM_BITS-1:0]   extra_v;
    logic [SUM_BITS-1:0]   n_sum;

    // Take the column from the right neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_pix_col <= i_col;
        end
    end

    // Drop rows and columns outside the image, weight the centre
    always_comb begin
        top_v   = i_ctl.row_top ? '0 : SUM_BITS'(r_pix_col.top);
        mid_v   = SUM_BITS'(r_pix_col.mid);
        bot_v   = i_ctl.row_bot ? '0 : SUM_BITS'(r_pix_col.bot);
        extra_v = i_ctl.centre ? (SUM_BITS'(r_pix_col.mid) << CENTRE_SHIFT) : '0;
        n_sum   = i_ctl.col_off ? '0 : (top_v + mid_v + bot_v + extra_v);
    end

    // Hold the column sum for the divide stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_sum <= n_sum;
        end
    end

    assign o_col = r_pix_col;
    assign o_sum = r_sum;

endmodule

/* sv/wmf_divide.sv */
module wmf_divide (
    input  logic                                            i_clk,
    input  logic                                            i_advance,
    input  logic [wmf_pkg::WIN_COLS-1:0][wmf_pkg::SUM_BITS-1:0] i_sum,
    input  wmf_pkg::t_div                                   i_div,
    output logic [wmf_pkg::PIXEL_BITS-1:0]                  o_quot
);
    import wmf_pkg::*;

    logic [TOTAL_BITS-1:0] r_total;
    logic [RECIP_BITS-1:0] r_recip;
    logic [QUOT_BITS-1:0]  r_prod;
    logic [TOTAL_BITS-1:0] n_total;
    logic [QUOT_BITS-1:0]  n_prod;

    // Add the three column sums
    always_comb begin
        n_total = TOTAL_BITS'(i_sum[0]) + TOTAL_BITS'(i_sum[1]) + TOTAL_BITS'(i_sum[2]);
    end

    // Multiply by the scaled reciprocal
    always_comb begin
        n_prod = QUOT_BITS'(r_total) * QUOT_BITS'(r_recip);
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_total <= n_total;
            r_recip <= recip_of(i_div);
            r_prod  <= n_prod;
        end
    end

    assign o_quot = r_prod[RECIP_SHIFT +: PIXEL_BITS];

endmodule

/* sv/weighted_mean_3x3_filter.sv */
// Channel   Handshake                   Payload
// -------   -------------------------   --------------------------------
// input     i_in_valid / o_in_stall     i_opcode, i_pixel_in
// output    o_out_valid / i_out_stall   o_pixel_out, o_frame_last
// config    i_cfg_we                    i_cfg_index, i_cfg_data
//
// One request per clock is taken while o_in_stall is low.
// A result passes through the window cells, column sums, window total, reciprocal
// multiply and output register in turn.
// Input stalls only while both the output register and its skid entry are full.
// Reset clears counters and handshake state; the line buffer is not cleared.
`include "weighted_mean_3x3_filter_macros.svh"

module weighted_mean_3x3_filter #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [wmf_pkg::OPCODE_BITS-1:0]       i_opcode,
    input  logic [wmf_pkg::PIXEL_BITS-1:0]        i_pixel_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [wmf_pkg::PIXEL_BITS-1:0]        o_pixel_out,
    output logic                                  o_frame_last,
    input  logic                                  i_cfg_we,
    input  logic [wmf_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [wmf_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import wmf_pkg::*;

    localparam int AW          = $clog2(MAX_WIDTH);
    localparam int WW          = $clog2(MAX_WIDTH + 1);
    localparam int PW          = $clog2(MAX_WIDTH + 2);
    localparam int RESET_WIDTH = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int RESET_HEIGHT = 256;

    // Registers
    logic [WW-1:0]          r_cfg_w, n_cfg_w;
    logic [HEIGHT_BITS-1:0] r_cfg_h, n_cfg_h;
    logic [WW-1:0]          r_geo_w, n_geo_w;
    logic [HEIGHT_BITS-1:0] r_geo_h, n_geo_h;
    logic [AW-1:0]          r_col, n_col;
    logic [ROW_BITS-1:0]    r_row, n_row;
    logic                   r_frame_done, n_frame_done;
    logic [PW-1:0]          r_pending, n_pending;
    logic [AW-1:0]          r_out_col, n_out_col;
    logic [ROW_BITS-1:0]    r_out_row, n_out_row;

    logic                   r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic                   r_a_top, r_a_bot, r_a_left, r_a_right;
    logic                   r_a_last, r_b_last, r_c_last, r_d_last;
    t_div                   r_a_div, r_b_div;

    logic                   r_o_valid, r_s_valid;
    t_result                r_o_data, r_s_data;

    // Combinational control
    logic                   advance;
    logic                   accept;
    logic                   is_pix;
    logic                   is_drain;
    logic                   start;
    logic                   new_frame;
    logic [WW-1:0]          eff_w;
    logic [HEIGHT_BITS-1:0] eff_h;
    logic [AW-1:0]          cur_col;
    logic [ROW_BITS-1:0]    cur_row;
    logic [WW-1:0]          col_inc;
    logic                   col_wrap;
    logic [HEIGHT_BITS-1:0] row_inc;
    logic                   row_wrap;
    logic [PW-1:0]          pend_base;
    logic [PW-1:0]          pend_inc;
    logic                   emit_pix;
    logic                   drain_go;
    logic                   emit;
    logic                   shift;
    logic                   wr_en;
    logic [WW-1:0]          out_col_inc;
    logic [WIDTH_CFG_BITS-1:0] cfg_w_raw;

    logic                   pos_top, pos_bot, pos_left, pos_right, pos_last;
    t_div                   pos_div;

    logic                   push;
    logic                   pop;
    t_result                push_data;

    t_column                col_chain [WIN_COLS+1];
    t_cell_ctl              cell_ctl  [WIN_COLS];
    logic [WIN_COLS-1:0][SUM_BITS-1:0] col_sum;
    logic [PIXEL_BITS-1:0]  quot;

    assign advance    = !r_s_valid;
    assign o_in_stall = r_s_valid;

    // Clamp configuration writes into range
    always_comb begin
        n_cfg_w   = r_cfg_w;
        n_cfg_h   = r_cfg_h;
        cfg_w_raw = i_cfg_data[WIDTH_CFG_BITS-1:0];
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    if (int'(cfg_w_raw) < SIDE_MIN) begin
                        n_cfg_w = WW'(SIDE_MIN);
                    end else if (int'(cfg_w_raw) > MAX_WIDTH) begin
                        n_cfg_w = WW'(MAX_WIDTH);
                    end else begin
                        n_cfg_w = WW'(cfg_w_raw);
                    end
                end
                CFG_FRAME_HEIGHT: begin
                    if (int'(i_cfg_data) < SIDE_MIN) begin
                        n_cfg_h = HEIGHT_BITS'(SIDE_MIN);
                    end else if (int'(i_cfg_data) > HEIGHT_MAX) begin
                        n_cfg_h = HEIGHT_BITS'(HEIGHT_MAX);
                    end else begin
                        n_cfg_h = i_cfg_data;
                    end
                end
                default: begin
                    n_cfg_w = r_cfg_w;
                end
            endcase
        end
    end

    // Decode the request and advance the raster counters
    always_comb begin
        accept    = i_in_valid && advance;
        is_pix    = (i_opcode == OP_PIXEL);
        is_drain  = (i_opcode == OP_DRAIN);
        start     = r_frame_done || ((r_col == '0) && (r_row == '0));
        new_frame = is_pix && start;
        eff_w     = new_frame ? r_cfg_w : r_geo_w;
        eff_h     = new_frame ? r_cfg_h : r_geo_h;
        cur_col   = (is_pix && r_frame_done) ? '0 : r_col;
        cur_row   = r_frame_done ? '0 : r_row;
        col_inc   = WW'(cur_col) + WW'(1);
        col_wrap  = (col_inc >= eff_w);
        row_inc   = HEIGHT_BITS'(cur_row) + HEIGHT_BITS'(1);
        row_wrap  = (row_inc >= eff_h);
        pend_base = new_frame ? '0 : r_pending;
        pend_inc  = pend_base + PW'(1);
        emit_pix  = (pend_inc > (PW'(eff_w) + PW'(1)));
        drain_go  = is_drain && r_frame_done && (r_pending != '0);
        emit      = accept && (is_pix ? emit_pix : drain_go);
        shift     = accept && (is_pix || drain_go);
        wr_en     = accept && is_pix;

        n_col        = r_col;
        n_row        = r_row;
        n_frame_done = r_frame_done;
        n_pending    = r_pending;
        n_geo_w      = r_geo_w;
        n_geo_h      = r_geo_h;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;

        if (shift) begin
            n_col = col_wrap ? '0 : AW'(col_inc);
        end

        if (wr_en) begin
            n_row        = col_wrap ? (row_wrap ? '0 : ROW_BITS'(row_inc)) : cur_row;
            n_frame_done = col_wrap && row_wrap;
            n_pending    = emit_pix ? pend_base : pend_inc;
            if (new_frame) begin
                n_geo_w   = r_cfg_w;
                n_geo_h   = r_cfg_h;
                n_out_col = '0;
                n_out_row = '0;
            end
        end else if (accept && drain_go) begin
            n_pending = r_pending - PW'(1);
        end

        // Step the output position
        out_col_inc = WW'(r_out_col) + WW'(1);
        if (emit) begin
            if (out_col_inc >= r_geo_w) begin
                n_out_col = '0;
                n_out_row = r_out_row + ROW_BITS'(1);
            end else begin
                n_out_col = AW'(out_col_inc);
            end
        end
    end

    // Border flags and divisor for the result being formed
    always_comb begin
        pos_top   = (r_out_row == '0);
        pos_bot   = (HEIGHT_BITS'(r_out_row) == (r_geo_h - HEIGHT_BITS'(1)));
        pos_left  = (r_out_col == '0);
        pos_right = (WW'(r_out_col) == (r_geo_w - WW'(1)));
        pos_last  = pos_bot && pos_right;
        if ((pos_top || pos_bot) && (pos_left || pos_right)) begin
            pos_div = DIV_CORNER;
        end else if (pos_top || pos_bot || pos_left || pos_right) begin
            pos_div = DIV_EDGE;
        end else begin
            pos_div = DIV_INNER;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w      <= WW'(RESET_WIDTH);
            r_cfg_h      <= HEIGHT_BITS'(RESET_HEIGHT);
            r_geo_w      <= WW'(RESET_WIDTH);
            r_geo_h      <= HEIGHT_BITS'(RESET_HEIGHT);
            r_col        <= '0;
            r_row        <= '0;
            r_frame_done <= 1'b0;
            r_pending    <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_c_valid    <= 1'b0;
            r_d_valid    <= 1'b0;
        end else begin
            r_cfg_w      <= n_cfg_w;
            r_cfg_h      <= n_cfg_h;
            r_geo_w      <= n_geo_w;
            r_geo_h      <= n_geo_h;
            r_col        <= n_col;
            r_row        <= n_row;
            r_frame_done <= n_frame_done;
            r_pending    <= n_pending;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
            if (advance) begin
                r_a_valid <= emit;
                r_b_valid <= r_a_valid;
                r_c_valid <= r_b_valid;
                r_d_valid <= r_c_valid;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_top   <= pos_top;
            r_a_bot   <= pos_bot;
            r_a_left  <= pos_left;
            r_a_right <= pos_right;
            r_a_last  <= pos_last;
            r_a_div   <= pos_div;
            r_b_last  <= r_a_last;
            r_b_div   <= r_a_div;
            r_c_last  <= r_b_last;
            r_d_last  <= r_c_last;
        end
    end

    // Line buffer feeds the entering column
    wmf_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (cur_col),
        .i_rd_addr (n_col),
        .i_pixel   (i_pixel_in),
        .o_col     (col_chain[0])
    );

    // Cell zero holds the right column, cell two the left
    always_comb begin
        for (int k = 0; k < WIN_COLS; k++) begin
            cell_ctl[k].shift   = shift;
            cell_ctl[k].advance = advance;
            cell_ctl[k].row_top = r_a_top;
            cell_ctl[k].row_bot = r_a_bot;
            cell_ctl[k].col_off = 1'b0;
            cell_ctl[k].centre  = (k == 1);
        end
        cell_ctl[0].col_off          = r_a_right;
        cell_ctl[WIN_COLS-1].col_off = r_a_left;
    end

    for (genvar g = 0; g < WIN_COLS; g++) begin : g_cell
        wmf_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (cell_ctl[g]),
            .i_col (col_chain[g]),
            .o_col (col_chain[g+1]),
            .o_sum (col_sum[g])
        );
    end

    wmf_divide u_divide (
        .i_clk     (i_clk),
        .i_advance (advance),
        .i_sum     (col_sum),
        .i_div     (r_b_div),
        .o_quot    (quot)
    );

    // Output register with one skid entry
    always_comb begin
        push            = advance && r_d_valid;
        pop             = r_o_valid && !i_out_stall;
        push_data.pixel = quot;
        push_data.last  = r_d_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            if (r_s_valid) begin
                if (pop) begin
                    r_s_valid <= 1'b0;
                end
            end else if (r_o_valid && !pop) begin
                r_s_valid <= push;
            end else begin
                r_o_valid <= push;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s_valid) begin
            if (pop) begin
                r_o_data <= r_s_data;
            end
        end else if (r_o_valid && !pop) begin
            if (push) begin
                r_s_data <= push_data;
            end
        end else begin
            r_o_data <= push_data;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_pixel_out  = r_o_data.pixel;
    assign o_frame_last = r_o_data.last;

    `WMF_ASSERT_ALWAYS(a_skid_behind_output, i_clk, i_rst_n, !r_s_valid || r_o_valid, "skid entry full while output register empty")
    `WMF_ASSERT_ALWAYS(a_pending_bounded, i_clk, i_rst_n, r_pending <= (PW'(r_geo_w) + PW'(1)), "pending count above one row plus one")
    `WMF_ASSERT_NEXT(a_last_empties, i_clk, i_rst_n, emit && pos_last, r_pending == '0, "results pending after last result of frame")

endmodule
